>>> sv/hwcs_pkg.sv
// Shared types, character codes and helpers for the HTML whitespace/comment stripper.
`default_nettype none
package hwcs_pkg;

	localparam int BYTE_W    = 8;
	localparam int WIN_DEPTH = 3;
	localparam int ENT_BYTES = WIN_DEPTH + 1;
	localparam int CNT_W     = $clog2(ENT_BYTES + 1);
	localparam int IDX_W     = $clog2(ENT_BYTES);
	localparam int WCNT_W    = $clog2(WIN_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
	localparam logic [BYTE_W-1:0] CH_DQUOT = 8'h22;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t [ENT_BYTES-1:0] b;
		logic  [CNT_W-1:0]     n;
		logic                  flush;
	} entry_t;

	function automatic logic is_ws(input byte_t c);
		is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage
`default_nettype wire

>>> sv/html_whitespace_comment_stripper_top.sv
// Top level of the HTML whitespace and comment stripper.
//
// Bytes of HTML text enter one item per clock unless in_stall is high; each byte is decided
// three items after it arrives, once the bytes after it are known, so "<!--" and "-->" can be
// spotted. A normal item passes once through the back end's decision step and gives at most
// one output item, so the sustained rate is one item per clock while out_stall is low. The
// item flagged end_of_text drains the lookahead window: the back end decides each pending
// byte (one to four) in turn, then sends the final item carrying last. A two-entry queue
// sits between the window logic and the decision step, and a registered output holds a
// result until it is taken; the back end waits while that result is stalled and advances in
// the cycle it is taken. remove_comments resets to 1;
// write it only between texts.
`default_nettype none
module html_whitespace_comment_stripper_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              remove_comments,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire hwcs_pkg::byte_t   in_byte,
	input  wire logic              end_of_text,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output hwcs_pkg::byte_t        out_byte,
	output logic                   byte_valid,
	output logic                   last
);

	logic             q_full;
	logic             q_push;
	hwcs_pkg::entry_t q_data;
	logic             q_pop;
	logic             q_head_valid;
	hwcs_pkg::entry_t q_head;

	assign cfg_ready = 1'b1;

	hwcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	hwcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	hwcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_value  (remove_comments),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last)
	);

endmodule
`default_nettype wire

>>> sv/hwcs_front.sv
// Front end: lookahead window that packs accepted bytes into queue entries.
`default_nettype none
module hwcs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire hwcs_pkg::byte_t   in_byte,
	input  wire logic              end_of_text,
	input  wire logic              q_full,
	output logic                   q_push,
	output hwcs_pkg::entry_t       q_data
);

	hwcs_pkg::byte_t [hwcs_pkg::WIN_DEPTH-1:0] win_q;
	logic [hwcs_pkg::WCNT_W-1:0]               cnt_q;
	logic                                      accept;
	logic                                      win_full;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign win_full = (cnt_q == hwcs_pkg::WCNT_W'(hwcs_pkg::WIN_DEPTH));
	assign q_push   = accept && (end_of_text || win_full);

	always_comb begin
		q_data.b[0] = (cnt_q > 2'd0) ? win_q[0] : ((cnt_q == 2'd0) ? in_byte : 8'h00);
		q_data.b[1] = (cnt_q > 2'd1) ? win_q[1] : ((cnt_q == 2'd1) ? in_byte : 8'h00);
		q_data.b[2] = (cnt_q > 2'd2) ? win_q[2] : ((cnt_q == 2'd2) ? in_byte : 8'h00);
		q_data.b[3] = (cnt_q == 2'd3) ? in_byte : 8'h00;
		q_data.n     = {1'b0, cnt_q} + 3'd1;
		q_data.flush = end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			win_q <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				cnt_q <= '0;
				win_q <= '0;
			end else if (win_full) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= in_byte;
			end else begin
				win_q[cnt_q[1:0]] <= in_byte;
				cnt_q             <= cnt_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/hwcs_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module hwcs_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hwcs_pkg::entry_t  push_data,
	input  wire logic              pop,
	output logic                   full,
	output logic                   head_valid,
	output hwcs_pkg::entry_t       head
);

	hwcs_pkg::entry_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/hwcs_back.sv
// Back end: per-byte decision sequencer, text context state and output register.
`default_nettype none
module hwcs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic              cfg_value,
	input  wire logic              head_valid,
	input  wire hwcs_pkg::entry_t  head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output hwcs_pkg::byte_t        out_byte,
	output logic                   byte_valid,
	output logic                   last
);

	logic                         remove_comments_q;
	logic                         inside_tag_q;
	logic                         inside_quote_q;
	hwcs_pkg::byte_t              open_quote_q;
	logic                         inside_comment_q;
	logic [1:0]                   skip_q;
	logic                         prev_space_q;
	logic                         any_emitted_q;
	logic [hwcs_pkg::IDX_W-1:0]   idx_q;
	logic                         fin_q;
	logic                         held_valid_q;
	hwcs_pkg::byte_t              held_q;
	logic                         out_valid_q;
	hwcs_pkg::byte_t              out_byte_q;
	logic                         byte_valid_q;
	logic                         last_q;

	logic                         out_free;
	logic                         step;
	logic [hwcs_pkg::IDX_W-1:0]   idx;
	hwcs_pkg::byte_t              c, n1, n2, n3;
	logic                         have3, have2, at_end;
	logic                         emit;
	hwcs_pkg::byte_t              ech;
	logic                         nx_tag, nx_quote, nx_comment, nx_prev, nx_any;
	hwcs_pkg::byte_t              nx_open;
	logic [1:0]                   nx_skip;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = head_valid && out_free;
	assign idx      = head.flush ? idx_q : '0;
	assign c        = head.b[idx];
	assign n1       = head.b[idx + 2'd1];
	assign n2       = head.b[idx + 2'd2];
	assign n3       = head.b[idx + 2'd3];
	assign have3    = ({1'b0, idx} + 3'd3) < head.n;
	assign have2    = ({1'b0, idx} + 3'd2) < head.n;
	assign at_end   = ({1'b0, idx} + 3'd1) == head.n;
	assign pop      = step && (!head.flush || fin_q);

	always_comb begin
		emit       = 1'b0;
		ech        = c;
		nx_tag     = inside_tag_q;
		nx_quote   = inside_quote_q;
		nx_open    = open_quote_q;
		nx_comment = inside_comment_q;
		nx_skip    = skip_q;
		nx_prev    = prev_space_q;
		nx_any     = any_emitted_q;
		if (skip_q != 2'd0) begin
			nx_skip = skip_q - 2'd1;
		end else if (remove_comments_q && !inside_quote_q && !inside_comment_q && have3 &&
				c == hwcs_pkg::CH_LT && n1 == hwcs_pkg::CH_BANG &&
				n2 == hwcs_pkg::CH_DASH && n3 == hwcs_pkg::CH_DASH) begin
			nx_comment = 1'b1;
		end else if (inside_comment_q && have2 && c == hwcs_pkg::CH_DASH &&
				n1 == hwcs_pkg::CH_DASH && n2 == hwcs_pkg::CH_GT) begin
			nx_comment = 1'b0;
			nx_skip    = 2'd2;
		end else if (inside_comment_q) begin
			nx_comment = 1'b1;
		end else if (hwcs_pkg::is_ws(c) &&
				!(inside_tag_q && (c == hwcs_pkg::CH_DQUOT || c == hwcs_pkg::CH_APOS))) begin
			if (!prev_space_q && any_emitted_q) begin
				emit    = 1'b1;
				ech     = hwcs_pkg::CH_SPACE;
				nx_prev = 1'b1;
			end
		end else begin
			if (inside_tag_q && (c == hwcs_pkg::CH_DQUOT || c == hwcs_pkg::CH_APOS)) begin
				if (!inside_quote_q) begin
					nx_quote = 1'b1;
					nx_open  = c;
				end else if (c == open_quote_q) begin
					nx_quote = 1'b0;
				end
			end else if (c == hwcs_pkg::CH_LT) begin
				nx_tag = 1'b1;
			end else if (c == hwcs_pkg::CH_GT) begin
				nx_tag   = 1'b0;
				nx_quote = 1'b0;
			end
			emit    = 1'b1;
			nx_prev = 1'b0;
			nx_any  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_comments_q <= 1'b1;
		end else if (cfg_write) begin
			remove_comments_q <= cfg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q     <= 1'b0;
			inside_quote_q   <= 1'b0;
			open_quote_q     <= '0;
			inside_comment_q <= 1'b0;
			skip_q           <= '0;
			prev_space_q     <= 1'b0;
			any_emitted_q    <= 1'b0;
			idx_q            <= '0;
			fin_q            <= 1'b0;
			held_valid_q     <= 1'b0;
			held_q           <= '0;
			out_valid_q      <= 1'b0;
			out_byte_q       <= '0;
			byte_valid_q     <= 1'b0;
			last_q           <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (head.flush && fin_q) begin
					// drain held byte as the final item, or a bare end marker
					out_valid_q      <= 1'b1;
					out_byte_q       <= held_valid_q ? held_q : '0;
					byte_valid_q     <= held_valid_q;
					last_q           <= 1'b1;
					held_valid_q     <= 1'b0;
					fin_q            <= 1'b0;
					idx_q            <= '0;
					inside_tag_q     <= 1'b0;
					inside_quote_q   <= 1'b0;
					open_quote_q     <= '0;
					inside_comment_q <= 1'b0;
					skip_q           <= '0;
					prev_space_q     <= 1'b0;
					any_emitted_q    <= 1'b0;
				end else begin
					inside_tag_q     <= nx_tag;
					inside_quote_q   <= nx_quote;
					open_quote_q     <= nx_open;
					inside_comment_q <= nx_comment;
					skip_q           <= nx_skip;
					prev_space_q     <= nx_prev;
					any_emitted_q    <= nx_any;
					if (head.flush) begin
						if (emit) begin
							held_q       <= ech;
							held_valid_q <= 1'b1;
							if (held_valid_q) begin
								out_valid_q  <= 1'b1;
								out_byte_q   <= held_q;
								byte_valid_q <= 1'b1;
								last_q       <= 1'b0;
							end
						end
						if (at_end) begin
							fin_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else if (emit) begin
						out_valid_q  <= 1'b1;
						out_byte_q   <= ech;
						byte_valid_q <= 1'b1;
						last_q       <= 1'b0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> sim/html_whitespace_comment_stripper_top_test.sv
// Self-checking testbench for the HTML whitespace and comment stripper top level.
module html_whitespace_comment_stripper_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_BYTES   = 50;

	typedef struct packed {
		hwcs_pkg::byte_t data;
		logic            valid;
		logic            last;
	} char_out_t;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_valid   = 1'b0;
	logic            cfg_ready;
	logic            cfg_remove  = 1'b1;
	logic            in_valid    = 1'b0;
	logic            in_stall;
	hwcs_pkg::byte_t in_byte     = '0;
	logic            end_of_text = 1'b0;
	logic            out_valid;
	logic            out_stall   = 1'b0;
	hwcs_pkg::byte_t out_byte;
	logic            byte_valid;
	logic            last;

	// predictor state
	logic            strip_comments = 1'b1;
	hwcs_pkg::byte_t win [hwcs_pkg::WIN_DEPTH];
	int              win_n;
	logic            in_tag;
	logic            quote_open;
	hwcs_pkg::byte_t quote_ch;
	logic            cmt_open;
	int              skip_n;
	logic            prev_space;
	logic            emitted_any;

	char_out_t   expected_chars[$];
	int          errors        = 0;
	int          chars_checked = 0;
	int          bytes_sent    = 0;
	int          texts_sent    = 0;
	int          mode_writes   = 0;
	int          send_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          hold_seq      = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;

	always #5 clk = ~clk;

	html_whitespace_comment_stripper_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.remove_comments (cfg_remove),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.end_of_text     (end_of_text),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.byte_valid      (byte_valid),
		.last            (last)
	);

	task automatic report_error(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void reset_text_context();
		for (int j = 0; j < hwcs_pkg::WIN_DEPTH; j++) win[j] = '0;
		win_n       = 0;
		in_tag      = 1'b0;
		quote_open  = 1'b0;
		quote_ch    = '0;
		cmt_open    = 1'b0;
		skip_n      = 0;
		prev_space  = 1'b0;
		emitted_any = 1'b0;
	endfunction

	function automatic logic is_blank(input hwcs_pkg::byte_t c);
		return (c == hwcs_pkg::CH_SPACE) || (c >= hwcs_pkg::CH_TAB && c <= hwcs_pkg::CH_CR);
	endfunction

	function automatic logic decide_char(input hwcs_pkg::byte_t b [hwcs_pkg::ENT_BYTES],
			input int n, input int i, output hwcs_pkg::byte_t ch);
		hwcs_pkg::byte_t c;
		c  = b[i];
		ch = '0;
		if (skip_n > 0) begin
			skip_n--;
			return 1'b0;
		end
		if (strip_comments && !quote_open && !cmt_open && i + 3 < n &&
				c == hwcs_pkg::CH_LT && b[i+1] == hwcs_pkg::CH_BANG &&
				b[i+2] == hwcs_pkg::CH_DASH && b[i+3] == hwcs_pkg::CH_DASH) begin
			cmt_open = 1'b1;
			return 1'b0;
		end
		if (cmt_open && i + 2 < n && c == hwcs_pkg::CH_DASH && b[i+1] == hwcs_pkg::CH_DASH &&
				b[i+2] == hwcs_pkg::CH_GT) begin
			cmt_open = 1'b0;
			skip_n   = 2;
			return 1'b0;
		end
		if (cmt_open)
			return 1'b0;
		if (in_tag && (c == hwcs_pkg::CH_DQUOT || c == hwcs_pkg::CH_APOS)) begin
			if (!quote_open) begin
				quote_open = 1'b1;
				quote_ch   = c;
			end else if (c == quote_ch) begin
				quote_open = 1'b0;
			end
		end else if (c == hwcs_pkg::CH_LT) begin
			in_tag = 1'b1;
		end else if (c == hwcs_pkg::CH_GT) begin
			in_tag     = 1'b0;
			quote_open = 1'b0;
		end else if (is_blank(c)) begin
			if (!prev_space && emitted_any) begin
				ch         = hwcs_pkg::CH_SPACE;
				prev_space = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		ch          = c;
		prev_space  = 1'b0;
		emitted_any = 1'b1;
		return 1'b1;
	endfunction

	task automatic predict_byte(input hwcs_pkg::byte_t x, input logic eot);
		hwcs_pkg::byte_t b [hwcs_pkg::ENT_BYTES];
		char_out_t       res [hwcs_pkg::ENT_BYTES];
		hwcs_pkg::byte_t ch;
		int              n;
		int              k;
		n = win_n;
		for (int j = 0; j < n; j++) b[j] = win[j];
		b[n] = x;
		n++;
		if (!eot) begin
			if (n > hwcs_pkg::WIN_DEPTH) begin
				if (decide_char(b, n, 0, ch))
					expected_chars.push_back(char_out_t'{ch, 1'b1, 1'b0});
				for (int j = 0; j < hwcs_pkg::WIN_DEPTH; j++) win[j] = b[j+1];
				win_n = hwcs_pkg::WIN_DEPTH;
			end else begin
				for (int j = 0; j < n; j++) win[j] = b[j];
				win_n = n;
			end
		end else begin
			k = 0;
			for (int j = 0; j < n; j++) begin
				if (decide_char(b, n, j, ch)) begin
					res[k] = char_out_t'{ch, 1'b1, 1'b0};
					k++;
				end
			end
			if (k == 0) begin
				res[0] = char_out_t'{8'h00, 1'b0, 1'b1};
				k = 1;
			end else begin
				res[k-1].last = 1'b1;
			end
			for (int j = 0; j < k; j++) expected_chars.push_back(res[j]);
			reset_text_context();
		end
	endtask

	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		char_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				report_error($sformatf({"unexpected item: expected none, got out_byte %02h",
					" byte_valid %b last %b"}, out_byte, byte_valid, last));
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (out_byte !== want.data)
					report_error($sformatf("out_byte expected %02h got %02h",
						want.data, out_byte));
				if (byte_valid !== want.valid)
					report_error($sformatf("byte_valid expected %b got %b",
						want.valid, byte_valid));
				if (last !== want.last)
					report_error($sformatf("last expected %b got %b", want.last, last));
			end
		end
	end

	task automatic send_byte(input hwcs_pkg::byte_t x, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= x;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(x, eot);
		bytes_sent++;
		if (eot)
			texts_sent++;
	endtask

	task automatic send_text(input hwcs_pkg::byte_t txt[$]);
		for (int j = 0; j < txt.size(); j++) send_byte(txt[j], j == txt.size() - 1);
	endtask

	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_chars.size() != 0) begin
			report_error($sformatf("%0d expected item(s) never arrived",
				expected_chars.size()));
			expected_chars.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_comment_mode(input logic mode);
		cfg_valid  <= 1'b1;
		cfg_remove <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid      <= 1'b0;
		strip_comments  = mode;
		mode_writes++;
	endtask

	function automatic void add_str(ref hwcs_pkg::byte_t q[$], input string s);
		for (int j = 0; j < s.len(); j++) q.push_back(hwcs_pkg::byte_t'(s[j]));
	endfunction

	function automatic hwcs_pkg::byte_t rand_letter();
		return hwcs_pkg::byte_t'(8'h61 + $urandom_range(25));
	endfunction

	function automatic hwcs_pkg::byte_t rand_blank();
		if ($urandom_range(5) == 5)
			return hwcs_pkg::CH_SPACE;
		return hwcs_pkg::byte_t'(hwcs_pkg::CH_TAB + $urandom_range(4));
	endfunction

	function automatic void add_word(ref hwcs_pkg::byte_t q[$], input int max_len);
		repeat ($urandom_range(1, max_len)) q.push_back(rand_letter());
	endfunction

	function automatic hwcs_pkg::byte_t rand_inner();
		case ($urandom_range(7))
			0, 1:    return rand_letter();
			2:       return rand_blank();
			3:       return hwcs_pkg::CH_DASH;
			4:       return hwcs_pkg::CH_GT;
			5:       return hwcs_pkg::CH_LT;
			6:       return ($urandom_range(1)) ? hwcs_pkg::CH_APOS : hwcs_pkg::CH_DQUOT;
			default: return hwcs_pkg::CH_BANG;
		endcase
	endfunction

	function automatic void random_text(ref hwcs_pkg::byte_t txt[$]);
		hwcs_pkg::byte_t q;
		txt.delete();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(9))
				0, 1: add_word(txt, 5);
				2: repeat ($urandom_range(1, 3)) txt.push_back(rand_blank());
				3: begin
					txt.push_back(hwcs_pkg::CH_LT);
					add_word(txt, 3);
					repeat ($urandom_range(2)) begin
						repeat ($urandom_range(1, 2)) txt.push_back(rand_blank());
						add_word(txt, 3);
						add_str(txt, "=");
						q = ($urandom_range(1)) ? hwcs_pkg::CH_APOS : hwcs_pkg::CH_DQUOT;
						txt.push_back(q);
						repeat ($urandom_range(4)) txt.push_back(rand_inner());
						if ($urandom_range(7) != 0)
							txt.push_back(q);
					end
					if ($urandom_range(1))
						txt.push_back(rand_blank());
					txt.push_back(hwcs_pkg::CH_GT);
				end
				4: begin
					add_str(txt, "</");
					add_word(txt, 3);
					txt.push_back(hwcs_pkg::CH_GT);
				end
				5: begin
					add_str(txt, "<!--");
					repeat ($urandom_range(5)) txt.push_back(rand_inner());
					add_str(txt, "-->");
				end
				6: begin
					case ($urandom_range(6))
						0: add_str(txt, "<!-");
						1: add_str(txt, "<!");
						2: add_str(txt, "--");
						3: add_str(txt, "->");
						4: add_str(txt, "-->");
						5: add_str(txt, "<!-x-");
						default: add_str(txt, "<!--");
					endcase
				end
				7: repeat ($urandom_range(1, 4))
					txt.push_back(hwcs_pkg::byte_t'($urandom_range(255)));
				8: txt.push_back(($urandom_range(1)) ? hwcs_pkg::CH_APOS : hwcs_pkg::CH_DQUOT);
				default: begin
					add_word(txt, 3);
					txt.push_back(hwcs_pkg::CH_APOS);
					add_word(txt, 2);
				end
			endcase
		end
	endfunction

	task automatic test_directed_cases();
		hwcs_pkg::byte_t txt[$];
		txt = '{hwcs_pkg::CH_SPACE};
		send_text(txt);
		txt.delete();
		add_str(txt, "<!---->");
		txt.push_back(8'hFF);
		send_text(txt);
		txt.delete();
		add_str(txt, "x' ");
		txt.push_back(hwcs_pkg::CH_TAB);
		add_str(txt, "<q ' >");
		send_text(txt);
		txt.delete();
		add_str(txt, "<!-");
		send_text(txt);
		txt.delete();
		add_str(txt, "<!--");
		send_text(txt);
		txt = '{8'h00, hwcs_pkg::CH_CR};
		send_text(txt);
		drain_results();
	endtask

	task automatic test_comment_mode();
		hwcs_pkg::byte_t txt[$];
		write_comment_mode(1'b0);
		add_str(txt, "<!--a-->b");
		send_text(txt);
		repeat (3) begin
			random_text(txt);
			send_text(txt);
		end
		drain_results();
		write_comment_mode(1'b1);
	endtask

	task automatic test_random_phase(input int send_pct, input int rcv_pct, input logic mode);
		hwcs_pkg::byte_t txt[$];
		int              start;
		send_idle_pct  = send_pct;
		rcv_stall_pct <= rcv_pct;
		write_comment_mode(mode);
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			random_text(txt);
			send_text(txt);
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		hwcs_pkg::byte_t txt[$];
		send_idle_pct  = 0;
		rcv_stall_pct <= 0;
		hold_seq      <= hold_seq + 1;
		repeat (6) add_str(txt, "<b>word</b> ");
		for (int j = 0; j < 36; j++) send_byte(txt[j], 1'b0);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		for (int j = 36; j < txt.size(); j++) send_byte(txt[j], j == txt.size() - 1);
		drain_results();
	endtask

	initial begin
		reset_text_context();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_comment_mode();
		test_random_phase(0, 0, 1'b1);
		test_random_phase(83, 0, 1'b0);
		test_random_phase(0, 83, 1'b1);
		test_random_phase(21, 21, 1'b0);
		test_backpressure();
		$display("Covered %0d texts, %0d input bytes, %0d output items checked,",
			texts_sent, bytes_sent, chars_checked);
		$display("with %0d comment mode writes and a %0d cycle output hold-off.",
			mode_writes, HOLD_CYCLES);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timed out", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
